### design/cwss_pkg.sv
// Shared types, constants and codes for the context-matched weight set selector.
package cwss_pkg;

    localparam int NUM_SETS = 10;
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int NUM_BYTES = 6;
    localparam int DIST_W   = 19;
    localparam int WT_W     = 20;
    localparam int RATE_W   = 16;
    localparam int CFG_W    = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_INIT  = '1;
    localparam logic [WT_W-1:0]   WT_ONE     = 20'd65536;
    localparam logic [WT_W-1:0]   WT_MAX     = 20'd655360;
    localparam logic [7:0]        FREE_BYTE  = 8'd128;

    localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd66;
    localparam logic [DIST_W-1:0] MATCH_RST      = 19'd90000;
    localparam logic [DIST_W-1:0] NEW_CTX_RST    = 19'd250000;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_DIST   = 2'd2;

    typedef logic [SET_W-1:0] set_idx_t;
    typedef logic [NUM_BYTES-1:0][7:0] ctx_vec_t;

    localparam ctx_vec_t CTX_FREE = {NUM_BYTES{FREE_BYTE}};

    typedef enum logic [1:0] {
        ACT_SELECT   = 2'd0,
        ACT_UPDATE   = 2'd1,
        ACT_FILL_WT  = 2'd2,
        ACT_FILL_CTX = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_MATCH   = 2'd0,
        KIND_NEUTRAL = 2'd1,
        KIND_NEW     = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD_MUL,
        ST_UPD_ADD,
        ST_FILL_WT,
        ST_FILL_CTX,
        ST_FINISH
    } state_t;

    // Token that travels down the row of cells during a select.
    typedef struct packed {
        logic              valid;
        ctx_vec_t          query;
        logic [DIST_W-1:0] best_dist;
        set_idx_t          best_idx;
        logic              free_found;
        set_idx_t          free_idx;
    } scan_t;

    // Write command from the controller to the row of cells.
    typedef struct packed {
        logic            ctx_we_all;
        logic            ctx_we_one;
        logic            wt_we_all;
        logic            wt_we_one;
        set_idx_t        slot;
        ctx_vec_t        ctx_data;
        logic [WT_W-1:0] wt_data;
    } wr_cmd_t;

    // Per-cell write enables and data after slot decoding.
    typedef struct packed {
        logic            ctx_we;
        logic            wt_we;
        ctx_vec_t        ctx_data;
        logic [WT_W-1:0] wt_data;
    } cell_cmd_t;

endpackage

### design/context_matched_weight_set_selector.sv
// Top level of the context-matched weight set selector: row of slot cells and sequencer.
//
// Usage. An item word is taken at a rising edge with start high and busy low; action picks
// select (0), update weight (1), fill weights (2) or fill contexts (3). Exactly one result
// word follows per item: selected_set, match_kind, current_weight and best_dist_sq are
// shown for one cycle with done high, and the receiver cannot stall them.
// A select sends a search token down the row of NUM_SETS cells, one cell per cycle; each
// cell adds its own distance and free-slot check; done rises after the token has left the
// last cell and the finish state has passed. An update runs a multiply state, then an
// add and clamp state. A new item may be taken in the cycle that done is high.
// Configuration words arrive on cfg_valid / cfg_index / cfg_data; cfg_ready is always
// high and an index beyond the register list is ignored. The user must write registers
// only while the block is idle; the block itself does not enforce this.
// Reset sets every stored context byte to 128, every weight to 1.0 (Q4.16), the current
// set to 0 and the registers to their default values; no clearing pass is needed.
module context_matched_weight_set_selector
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [7:0]                         ctx_byte_0,
    input  logic [7:0]                         ctx_byte_1,
    input  logic [7:0]                         ctx_byte_2,
    input  logic [7:0]                         ctx_byte_3,
    input  logic [7:0]                         ctx_byte_4,
    input  logic [7:0]                         ctx_byte_5,
    input  logic signed [7:0]                  reward_value,
    input  logic [19:0]                        weight_fill,
    input  logic [7:0]                         feature_fill,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cwss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwss_pkg::CFG_W-1:0]         cfg_data,
    output logic                               done,
    output logic [5:0]                         selected_set,
    output logic [1:0]                         match_kind,
    output logic [19:0]                        current_weight,
    output logic [18:0]                        best_dist_sq
);

    cwss_pkg::scan_t                 scan [cwss_pkg::NUM_SETS+1];
    logic [cwss_pkg::WT_W-1:0]       weights [cwss_pkg::NUM_SETS];
    cwss_pkg::cell_cmd_t             cell_cmd [cwss_pkg::NUM_SETS];
    cwss_pkg::wr_cmd_t               wr_cmd;
    cwss_pkg::set_idx_t              cur_set;
    cwss_pkg::ctx_vec_t              query;

    assign cfg_ready = 1'b1;
    assign query = {ctx_byte_5, ctx_byte_4, ctx_byte_3, ctx_byte_2, ctx_byte_1, ctx_byte_0};

    cwss_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .query          (query),
        .reward_value   (reward_value),
        .weight_fill    (weight_fill),
        .feature_fill   (feature_fill),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .launch         (scan[0]),
        .chain_end      (scan[cwss_pkg::NUM_SETS]),
        .weight_rd      (weights[cur_set]),
        .wr_cmd         (wr_cmd),
        .cur_set        (cur_set),
        .done           (done),
        .selected_set   (selected_set),
        .match_kind     (match_kind),
        .current_weight (current_weight),
        .best_dist_sq   (best_dist_sq)
    );

    for (genvar i = 0; i < cwss_pkg::NUM_SETS; i++)
    begin : g_cell
        always_comb
        begin
            cell_cmd[i].ctx_we   = wr_cmd.ctx_we_all ||
                (wr_cmd.ctx_we_one && (wr_cmd.slot == cwss_pkg::set_idx_t'(i)));
            cell_cmd[i].wt_we    = wr_cmd.wt_we_all ||
                (wr_cmd.wt_we_one && (wr_cmd.slot == cwss_pkg::set_idx_t'(i)));
            cell_cmd[i].ctx_data = wr_cmd.ctx_data;
            cell_cmd[i].wt_data  = wr_cmd.wt_data;
        end

        cwss_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot     (cwss_pkg::set_idx_t'(i)),
            .cmd      (cell_cmd[i]),
            .scan_in  (scan[i]),
            .scan_out (scan[i+1]),
            .weight   (weights[i])
        );
    end

    // An accepted item keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // Every item produces a single one-cycle result word.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Non-select results carry a zero distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (match_kind == cwss_pkg::KIND_NONE)) |-> (best_dist_sq == '0))
        else $error("non-select result with non-zero distance");

    // The selected set always names an existing slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (selected_set < 6'(cwss_pkg::NUM_SETS)))
        else $error("selected set out of range");

    // The search token never reaches the end of the row unless a select is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan[cwss_pkg::NUM_SETS].valid |-> busy)
        else $error("search token finished while idle");

endmodule

### design/cwss_cell.sv
// One slot of the selector: stored context and weight, plus one step of the nearest search.
module cwss_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cwss_pkg::set_idx_t                 slot,
    input  cwss_pkg::cell_cmd_t                cmd,
    input  cwss_pkg::scan_t                    scan_in,
    output cwss_pkg::scan_t                    scan_out,
    output logic [cwss_pkg::WT_W-1:0]          weight
);

    cwss_pkg::ctx_vec_t              ctx_reg;
    logic [cwss_pkg::WT_W-1:0]       wt_reg;
    cwss_pkg::scan_t                 scan_reg;
    cwss_pkg::scan_t                 scan_next;
    logic [cwss_pkg::DIST_W-1:0]     dist_sum;
    logic                            is_free;

    always_comb
    begin
        logic [7:0]  ad;
        logic [15:0] sq;
        dist_sum = '0;
        for (int j = 0; j < cwss_pkg::NUM_BYTES; j++)
        begin
            ad = (ctx_reg[j] >= scan_in.query[j]) ? (ctx_reg[j] - scan_in.query[j])
                                                  : (scan_in.query[j] - ctx_reg[j]);
            sq = ad * ad;
            dist_sum = dist_sum + cwss_pkg::DIST_W'(sq);
        end
    end

    assign is_free = (ctx_reg == cwss_pkg::CTX_FREE);

    // Strictly smaller keeps the earliest slot on a tie.
    always_comb
    begin
        scan_next = scan_in;
        if (dist_sum < scan_in.best_dist)
        begin
            scan_next.best_dist = dist_sum;
            scan_next.best_idx  = slot;
        end
        if (!scan_in.free_found && is_free)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg  <= cwss_pkg::CTX_FREE;
            wt_reg   <= cwss_pkg::WT_ONE;
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            if (cmd.ctx_we)
            begin
                ctx_reg <= cmd.ctx_data;
            end
            if (cmd.wt_we)
            begin
                wt_reg <= cmd.wt_data;
            end
        end
    end

    assign scan_out = scan_reg;
    assign weight   = wt_reg;

endmodule

### design/cwss_ctrl.sv
// Sequencer of the selector: configuration registers, decision, weight update and result words.
module cwss_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  cwss_pkg::ctx_vec_t                 query,
    input  logic signed [7:0]                  reward_value,
    input  logic [cwss_pkg::WT_W-1:0]          weight_fill,
    input  logic [7:0]                         feature_fill,
    input  logic                               cfg_valid,
    input  logic [cwss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwss_pkg::CFG_W-1:0]         cfg_data,
    output cwss_pkg::scan_t                    launch,
    input  cwss_pkg::scan_t                    chain_end,
    input  logic [cwss_pkg::WT_W-1:0]          weight_rd,
    output cwss_pkg::wr_cmd_t                  wr_cmd,
    output cwss_pkg::set_idx_t                 cur_set,
    output logic                               done,
    output logic [5:0]                         selected_set,
    output logic [1:0]                         match_kind,
    output logic [cwss_pkg::WT_W-1:0]          current_weight,
    output logic [cwss_pkg::DIST_W-1:0]        best_dist_sq
);

    cwss_pkg::state_t                state_reg, state_next;
    cwss_pkg::kind_t                 kind_reg;
    logic [cwss_pkg::DIST_W-1:0]     best_reg;
    cwss_pkg::set_idx_t              cur_set_reg;
    logic signed [7:0]               reward_reg;
    logic [cwss_pkg::WT_W-1:0]       fill_wt_reg;
    logic [7:0]                      fill_ctx_reg;
    logic signed [42:0]              prod_reg;
    logic [cwss_pkg::RATE_W-1:0]     learn_rate_reg;
    logic [cwss_pkg::DIST_W-1:0]     match_dist_reg;
    logic [cwss_pkg::DIST_W-1:0]     new_dist_reg;
    logic                            done_reg;
    logic [5:0]                      sel_out_reg;
    cwss_pkg::kind_t                 kind_out_reg;
    logic [cwss_pkg::WT_W-1:0]       wt_out_reg;
    logic [cwss_pkg::DIST_W-1:0]     dist_out_reg;

    logic                            accept;
    cwss_pkg::kind_t                 dec_kind;
    cwss_pkg::set_idx_t              dec_slot;
    logic signed [25:0]              wt_diff;
    logic signed [26:0]              wt_step;
    logic signed [27:0]              wt_sum;
    logic [cwss_pkg::WT_W-1:0]       wt_new;

    assign busy   = (state_reg != cwss_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Outcome of a select once the token leaves the last cell.
    always_comb
    begin
        dec_slot = chain_end.free_found ? chain_end.free_idx : '0;
        priority if (chain_end.best_dist <= match_dist_reg)
        begin
            dec_kind = cwss_pkg::KIND_MATCH;
        end
        else if (chain_end.best_dist < new_dist_reg)
        begin
            dec_kind = cwss_pkg::KIND_NEUTRAL;
        end
        else
        begin
            dec_kind = cwss_pkg::KIND_NEW;
        end
    end

    // Update arithmetic: the top bits of the product are the arithmetic shift by 16.
    assign wt_diff = $signed({{2{reward_reg[7]}}, reward_reg, 16'b0})
                   - $signed({6'b0, weight_rd});
    assign wt_step = prod_reg[42:16];
    assign wt_sum  = 28'(wt_step) + $signed({8'b0, weight_rd});

    always_comb
    begin
        priority if (wt_sum < 0)
        begin
            wt_new = '0;
        end
        else if (wt_sum > $signed({8'b0, cwss_pkg::WT_MAX}))
        begin
            wt_new = cwss_pkg::WT_MAX;
        end
        else
        begin
            wt_new = wt_sum[cwss_pkg::WT_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cwss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cwss_pkg::action_t'(action))
                        cwss_pkg::ACT_SELECT:   state_next = cwss_pkg::ST_SCAN;
                        cwss_pkg::ACT_UPDATE:   state_next = cwss_pkg::ST_UPD_MUL;
                        cwss_pkg::ACT_FILL_WT:  state_next = cwss_pkg::ST_FILL_WT;
                        cwss_pkg::ACT_FILL_CTX: state_next = cwss_pkg::ST_FILL_CTX;
                        default:                state_next = cwss_pkg::ST_IDLE;
                    endcase
                end
            end
            cwss_pkg::ST_SCAN:
            begin
                if (chain_end.valid)
                begin
                    state_next = cwss_pkg::ST_FINISH;
                end
            end
            cwss_pkg::ST_UPD_MUL:  state_next = cwss_pkg::ST_UPD_ADD;
            cwss_pkg::ST_UPD_ADD:  state_next = cwss_pkg::ST_FINISH;
            cwss_pkg::ST_FILL_WT:  state_next = cwss_pkg::ST_FINISH;
            cwss_pkg::ST_FILL_CTX: state_next = cwss_pkg::ST_FINISH;
            cwss_pkg::ST_FINISH:   state_next = cwss_pkg::ST_IDLE;
            default:               state_next = cwss_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        launch            = '0;
        launch.valid      = accept && (cwss_pkg::action_t'(action) == cwss_pkg::ACT_SELECT);
        launch.query      = query;
        launch.best_dist  = cwss_pkg::DIST_INIT;

        wr_cmd          = '0;
        wr_cmd.slot     = cur_set_reg;
        wr_cmd.ctx_data = chain_end.query;
        wr_cmd.wt_data  = cwss_pkg::WT_ONE;
        unique case (state_reg)
            cwss_pkg::ST_SCAN:
            begin
                if (chain_end.valid)
                begin
                    if (dec_kind == cwss_pkg::KIND_NEUTRAL)
                    begin
                        wr_cmd.wt_we_one = 1'b1;
                    end
                    else if (dec_kind == cwss_pkg::KIND_NEW)
                    begin
                        wr_cmd.slot       = dec_slot;
                        wr_cmd.ctx_we_one = 1'b1;
                        wr_cmd.wt_we_one  = 1'b1;
                    end
                end
            end
            cwss_pkg::ST_UPD_ADD:
            begin
                wr_cmd.wt_we_one = 1'b1;
                wr_cmd.wt_data   = wt_new;
            end
            cwss_pkg::ST_FILL_WT:
            begin
                wr_cmd.wt_we_all = 1'b1;
                wr_cmd.wt_data   = fill_wt_reg;
            end
            cwss_pkg::ST_FILL_CTX:
            begin
                wr_cmd.ctx_we_all = 1'b1;
                wr_cmd.ctx_data   = {cwss_pkg::NUM_BYTES{fill_ctx_reg}};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cwss_pkg::ST_IDLE;
            cur_set_reg    <= '0;
            done_reg       <= 1'b0;
            learn_rate_reg <= cwss_pkg::LEARN_RATE_RST;
            match_dist_reg <= cwss_pkg::MATCH_RST;
            new_dist_reg   <= cwss_pkg::NEW_CTX_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == cwss_pkg::ST_FINISH);
            if (cfg_valid)
            begin
                if (cfg_index == cwss_pkg::CFG_LEARN_RATE)
                begin
                    learn_rate_reg <= cfg_data[cwss_pkg::RATE_W-1:0];
                end
                if (cfg_index == cwss_pkg::CFG_MATCH_DIST)
                begin
                    match_dist_reg <= cfg_data;
                end
                if (cfg_index == cwss_pkg::CFG_NEW_DIST)
                begin
                    new_dist_reg <= cfg_data;
                end
            end
            if ((state_reg == cwss_pkg::ST_SCAN) && chain_end.valid)
            begin
                if (dec_kind == cwss_pkg::KIND_MATCH)
                begin
                    cur_set_reg <= chain_end.best_idx;
                end
                else if (dec_kind == cwss_pkg::KIND_NEW)
                begin
                    cur_set_reg <= dec_slot;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= cwss_pkg::KIND_NONE;
            best_reg     <= '0;
            reward_reg   <= reward_value;
            fill_wt_reg  <= weight_fill;
            fill_ctx_reg <= feature_fill;
        end
        if ((state_reg == cwss_pkg::ST_SCAN) && chain_end.valid)
        begin
            kind_reg <= dec_kind;
            best_reg <= chain_end.best_dist;
        end
        if (state_reg == cwss_pkg::ST_UPD_MUL)
        begin
            prod_reg <= $signed({1'b0, learn_rate_reg}) * wt_diff;
        end
        if (state_reg == cwss_pkg::ST_FINISH)
        begin
            sel_out_reg  <= 6'(cur_set_reg);
            kind_out_reg <= kind_reg;
            wt_out_reg   <= weight_rd;
            dist_out_reg <= best_reg;
        end
    end

    assign cur_set        = cur_set_reg;
    assign done           = done_reg;
    assign selected_set   = sel_out_reg;
    assign match_kind     = kind_out_reg;
    assign current_weight = wt_out_reg;
    assign best_dist_sq   = dist_out_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the weight set selector: stimulus table, then random words.
`timescale 1ns / 1ps

module testbench;
    import cwss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SEL_LATENCY = NUM_SETS + 1;
    localparam ctx_vec_t CTX_ZERO = '0;
    localparam ctx_vec_t CTX_FULL = '1;
    localparam ctx_vec_t CTX_STRIPE = 48'hFF00_7FFE_8001;
    localparam ctx_vec_t CTX_CHECKER = 48'h55AA_55AA_55AA;

    typedef struct {
        action_t           act;
        ctx_vec_t          ctx;
        logic signed [7:0] reward;
        logic [WT_W-1:0]   wfill;
        logic [7:0]        ffill;
    } word_t;

    typedef struct {
        logic [5:0]        set;
        kind_t             kind;
        logic [WT_W-1:0]   weight;
        logic [DIST_W-1:0] dist_sq;
    } outcome_t;

    typedef struct {
        word_t    w;
        bit       typed;
        outcome_t res;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             action;
    logic [7:0]             ctx_byte_0;
    logic [7:0]             ctx_byte_1;
    logic [7:0]             ctx_byte_2;
    logic [7:0]             ctx_byte_3;
    logic [7:0]             ctx_byte_4;
    logic [7:0]             ctx_byte_5;
    logic signed [7:0]      reward_value;
    logic [19:0]            weight_fill;
    logic [7:0]             feature_fill;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   done;
    logic [5:0]             selected_set;
    logic [1:0]             match_kind;
    logic [19:0]            current_weight;
    logic [18:0]            best_dist_sq;

    // Predicted state of the selector.
    ctx_vec_t               slot_ctx [NUM_SETS];
    logic [WT_W-1:0]        slot_wt [NUM_SETS];
    int                     cur_slot;
    logic [RATE_W-1:0]      rate_cfg;
    logic [DIST_W-1:0]      match_cfg;
    logic [DIST_W-1:0]      newctx_cfg;

    outcome_t               pending_outcomes [$];
    row_t                   steps [$];

    int faults;
    int settings_used;
    int n_select, n_update, n_fill;
    int n_match, n_neutral, n_new;

    context_matched_weight_set_selector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .ctx_byte_0     (ctx_byte_0),
        .ctx_byte_1     (ctx_byte_1),
        .ctx_byte_2     (ctx_byte_2),
        .ctx_byte_3     (ctx_byte_3),
        .ctx_byte_4     (ctx_byte_4),
        .ctx_byte_5     (ctx_byte_5),
        .reward_value   (reward_value),
        .weight_fill    (weight_fill),
        .feature_fill   (feature_fill),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .selected_set   (selected_set),
        .match_kind     (match_kind),
        .current_weight (current_weight),
        .best_dist_sq   (best_dist_sq)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Applies one word to the predicted state and returns the result it should give.
    function automatic outcome_t advance_selector(word_t w);
        outcome_t o;
        int       best;
        int       best_idx;
        int       sq_sum;
        int       diff;
        int       slot;
        longint   cur_w;
        longint   delta;
        longint   next_w;
        best = 0;
        best_idx = 0;
        o.kind = KIND_NONE;
        case (w.act)
            ACT_SELECT:
            begin
                for (int i = 0; i < NUM_SETS; i++)
                begin
                    sq_sum = 0;
                    for (int j = 0; j < NUM_BYTES; j++)
                    begin
                        diff = int'(slot_ctx[i][j]) - int'(w.ctx[j]);
                        sq_sum += diff * diff;
                    end
                    // Strict compare keeps the lowest index on a tie.
                    if (i == 0 || sq_sum < best)
                    begin
                        best = sq_sum;
                        best_idx = i;
                    end
                end
                if (best <= int'(match_cfg))
                begin
                    cur_slot = best_idx;
                    o.kind = KIND_MATCH;
                end
                else if (best < int'(newctx_cfg))
                begin
                    slot_wt[cur_slot] = WT_ONE;
                    o.kind = KIND_NEUTRAL;
                end
                else
                begin
                    slot = 0;
                    for (int i = NUM_SETS - 1; i >= 0; i--)
                        if (slot_ctx[i] == CTX_FREE)
                            slot = i;
                    slot_ctx[slot] = w.ctx;
                    slot_wt[slot] = WT_ONE;
                    cur_slot = slot;
                    o.kind = KIND_NEW;
                end
            end
            ACT_UPDATE:
            begin
                cur_w = longint'(slot_wt[cur_slot]);
                delta = longint'(w.reward) * 65536 - cur_w;
                next_w = cur_w + ((longint'(rate_cfg) * delta) >>> 16);
                if (next_w < 0)
                    next_w = 0;
                if (next_w > longint'(WT_MAX))
                    next_w = longint'(WT_MAX);
                slot_wt[cur_slot] = next_w[WT_W-1:0];
            end
            ACT_FILL_WT:
            begin
                for (int i = 0; i < NUM_SETS; i++)
                    slot_wt[i] = w.wfill;
            end
            default:
            begin
                for (int i = 0; i < NUM_SETS; i++)
                    slot_ctx[i] = {NUM_BYTES{w.ffill}};
            end
        endcase
        o.set = 6'(cur_slot);
        o.weight = slot_wt[cur_slot];
        o.dist_sq = DIST_W'(best);
        return o;
    endfunction

    function automatic row_t row(action_t a, ctx_vec_t cx, int arg, bit typed,
                                 int s, kind_t k, int wt, int d);
        row_t r;
        r.w.act = a;
        r.w.ctx = cx;
        r.w.reward = 8'(arg);
        r.w.wfill = 20'(arg);
        r.w.ffill = 8'(arg);
        r.typed = typed;
        r.res.set = 6'(s);
        r.res.kind = k;
        r.res.weight = 20'(wt);
        r.res.dist_sq = 19'(d);
        return r;
    endfunction

    function automatic word_t random_word();
        word_t    w;
        ctx_vec_t base;
        int       pick;
        int       spread;
        int       v;
        w.ctx = 48'({$urandom, $urandom});
        w.reward = 8'($urandom);
        w.wfill = 20'($urandom_range(0, WT_MAX));
        w.ffill = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            w.act = ACT_SELECT;
            pick = $urandom_range(0, 9);
            // Most selects land near a stored context or near a free slot.
            if (pick < 6)
            begin
                base = (pick < 4) ? slot_ctx[$urandom_range(0, NUM_SETS - 1)] : CTX_FREE;
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 6;
                    2: spread = 40;
                    default: spread = 150;
                endcase
                for (int j = 0; j < NUM_BYTES; j++)
                begin
                    v = int'(base[j]) + int'($urandom_range(0, 2 * spread)) - spread;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    w.ctx[j] = 8'(v);
                end
            end
        end
        else if (pick < 88)
        begin
            w.act = ACT_UPDATE;
            if ($urandom_range(0, 1) == 0)
                w.reward = 8'($urandom_range(0, 10));
        end
        else if (pick < 96)
        begin
            w.act = ACT_FILL_WT;
            case ($urandom_range(0, 7))
                0: w.wfill = '0;
                1: w.wfill = WT_MAX;
                2: w.wfill = 20'($urandom);
                default: ;
            endcase
        end
        else
        begin
            w.act = ACT_FILL_CTX;
            if ($urandom_range(0, 1) == 0)
                w.ffill = FREE_BYTE;
        end
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_LEARN_RATE: rate_cfg = data[RATE_W-1:0];
            CFG_MATCH_DIST: match_cfg = data[DIST_W-1:0];
            CFG_NEW_DIST:   newctx_cfg = data[DIST_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(int rate, int match_d, int new_d);
        write_reg(CFG_LEARN_RATE, rate);
        write_reg(CFG_MATCH_DIST, match_d);
        write_reg(CFG_NEW_DIST, new_d);
        settings_used++;
    endtask

    task automatic send_word(word_t w, bit typed, outcome_t t);
        outcome_t o;
        @(negedge clk);
        start <= 1'b1;
        action <= w.act;
        ctx_byte_0 <= w.ctx[0];
        ctx_byte_1 <= w.ctx[1];
        ctx_byte_2 <= w.ctx[2];
        ctx_byte_3 <= w.ctx[3];
        ctx_byte_4 <= w.ctx[4];
        ctx_byte_5 <= w.ctx[5];
        reward_value <= w.reward;
        weight_fill <= w.wfill;
        feature_fill <= w.ffill;
        do @(posedge clk); while (busy);
        o = advance_selector(w);
        if (typed)
            pending_outcomes.push_back(t);
        else
            pending_outcomes.push_back(o);
        case (w.act)
            ACT_SELECT: n_select++;
            ACT_UPDATE: n_update++;
            default:    n_fill++;
        endcase
    endtask

    // Holds start low while the payload wanders.
    task automatic pause_sender(int n);
        @(negedge clk);
        start <= 1'b0;
        action <= 2'($urandom);
        reward_value <= 8'($urandom);
        feature_fill <= 8'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int n);
        outcome_t unused;
        int       left;
        left = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
        begin
            send_word(random_word(), 1'b0, unused);
            left--;
            if (left == 0)
            begin
                left = $urandom_range(1, 20);
                case ($urandom_range(0, 9))
                    0: drain();
                    1, 2, 3: ;
                    default: pause_sender($urandom_range(1, 15));
                endcase
            end
        end
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            faults++;
            if (faults <= 10)
                $display("mismatch on %s at %0t: expected %0d, got %0d", name, $time, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        outcome_t due;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("result word at %0t with nothing outstanding", $time);
            end
            else
            begin
                due = pending_outcomes.pop_front();
                compare_field("selected_set", 32'(due.set), 32'(selected_set));
                compare_field("match_kind", 32'(due.kind), 32'(match_kind));
                compare_field("current_weight", 32'(due.weight), 32'(current_weight));
                compare_field("best_dist_sq", 32'(due.dist_sq), 32'(best_dist_sq));
                case (match_kind)
                    KIND_MATCH:   n_match++;
                    KIND_NEUTRAL: n_neutral++;
                    KIND_NEW:     n_new++;
                    default: ;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_SELECT;
        ctx_byte_0 = '0;
        ctx_byte_1 = '0;
        ctx_byte_2 = '0;
        ctx_byte_3 = '0;
        ctx_byte_4 = '0;
        ctx_byte_5 = '0;
        reward_value = '0;
        weight_fill = '0;
        feature_fill = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LEARN_RATE;
        cfg_data = '0;
        faults = 0;
        settings_used = 1;
        n_select = 0;
        n_update = 0;
        n_fill = 0;
        n_match = 0;
        n_neutral = 0;
        n_new = 0;
        for (int i = 0; i < NUM_SETS; i++)
        begin
            slot_ctx[i] = CTX_FREE;
            slot_wt[i] = WT_ONE;
        end
        cur_slot = 0;
        rate_cfg = LEARN_RATE_RST;
        match_cfg = MATCH_RST;
        newctx_cfg = NEW_CTX_RST;

        // From reset no context lies far enough from the free slots to be stored.
        steps.push_back(row(ACT_SELECT, CTX_FREE, 0, 1, 0, KIND_MATCH, WT_ONE, 0));
        steps.push_back(row(ACT_SELECT, CTX_ZERO, 0, 1, 0, KIND_NEUTRAL, WT_ONE, 98304));
        steps.push_back(row(ACT_SELECT, CTX_FULL, 0, 1, 0, KIND_NEUTRAL, WT_ONE, 96774));
        steps.push_back(row(ACT_UPDATE, CTX_ZERO, 127, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_UPDATE, CTX_ZERO, -128, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_FILL_WT, CTX_ZERO, WT_MAX, 1, 0, KIND_NONE, WT_MAX, 0));
        steps.push_back(row(ACT_UPDATE, CTX_ZERO, 127, 1, 0, KIND_NONE, WT_MAX, 0));
        steps.push_back(row(ACT_FILL_WT, CTX_ZERO, 0, 1, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_UPDATE, CTX_ZERO, -128, 1, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_FILL_WT, CTX_ZERO, 1048575, 1, 0, KIND_NONE, 1048575, 0));
        steps.push_back(row(ACT_UPDATE, CTX_ZERO, 0, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_FILL_CTX, CTX_ZERO, 0, 0, 0, KIND_NONE, 0, 0));
        // No slot is free now, so the far context overwrites slot 0.
        steps.push_back(row(ACT_SELECT, CTX_FULL, 0, 1, 0, KIND_NEW, WT_ONE, 390150));
        steps.push_back(row(ACT_SELECT, CTX_FULL, 0, 1, 0, KIND_MATCH, WT_ONE, 0));
        // Slots one to nine tie at distance zero; the lowest wins.
        steps.push_back(row(ACT_SELECT, CTX_ZERO, 0, 1, 1, KIND_MATCH, 1048575, 0));
        steps.push_back(row(ACT_FILL_CTX, CTX_ZERO, FREE_BYTE, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_SELECT, CTX_STRIPE, 0, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_UPDATE, CTX_ZERO, 1, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_FILL_WT, CTX_ZERO, WT_ONE, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_SELECT, CTX_CHECKER, 0, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_FILL_CTX, CTX_ZERO, 255, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_SELECT, CTX_CHECKER, 0, 0, 0, KIND_NONE, 0, 0));
        steps.push_back(row(ACT_FILL_CTX, CTX_ZERO, FREE_BYTE, 0, 0, KIND_NONE, 0, 0));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (steps[i])
            send_word(steps[i].w, steps[i].typed, steps[i].res);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0: set_registers(65535, 0, 0);
                1: set_registers(0, 390150, 390151);
                2:
                begin
                    set_registers(1000, 20000, 60000);
                    write_reg(CFG_SPARE, $urandom_range(0, 524287));
                end
                3: set_registers(LEARN_RATE_RST, MATCH_RST, NEW_CTX_RST);
                default: set_registers($urandom_range(0, 65535), $urandom_range(0, 120000),
                                       $urandom_range(0, 390151));
            endcase
            random_phase(100);
        end

        drain();
        repeat (SEL_LATENCY + 4) @(posedge clk);

        $display("run covered %0d words: %0d selects (%0d matched, %0d neutral, %0d stored new),",
                 n_select + n_update + n_fill, n_select, n_match, n_neutral, n_new);
        $display("%0d updates and %0d fills over %0d register settings, %0d mismatches",
                 n_update, n_fill, settings_used, faults);
        if (faults == 0 && pending_outcomes.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
